// ===== hw/rtl/kbdsc_pkg.sv =====
package kbdsc_pkg;

   // Scancode set 1 codes with special handling
   localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2a;
   localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BRK  = 8'haa;
   localparam logic [7:0] SC_RSHIFT_BRK  = 8'hb6;
   localparam logic [7:0] SC_BACKSPACE   = 8'h0e;
   localparam logic [7:0] SC_TAB         = 8'h0f;

   // ASCII letter bounds and case offset
   localparam logic [6:0] ASCII_UPPER_A = 7'h41;
   localparam logic [6:0] ASCII_UPPER_Z = 7'h5a;
   localparam logic [6:0] CASE_OFFSET   = 7'h20;

   // Shift state: bit 0 left shift, bit 1 right shift
   typedef logic [1:0] shift_type;

   // Unshifted Japanese-layout map, zero for keys without a character
   function automatic logic [6:0] plain_char(input logic [6:0] code);
      logic [6:0] ch;
      case (code)
         7'h02: ch = 7'h31;
         7'h03: ch = 7'h32;
         7'h04: ch = 7'h33;
         7'h05: ch = 7'h34;
         7'h06: ch = 7'h35;
         7'h07: ch = 7'h36;
         7'h08: ch = 7'h37;
         7'h09: ch = 7'h38;
         7'h0a: ch = 7'h39;
         7'h0b: ch = 7'h30;
         7'h0c: ch = 7'h2d;
         7'h0d: ch = 7'h5e;
         7'h10: ch = 7'h51;
         7'h11: ch = 7'h57;
         7'h12: ch = 7'h45;
         7'h13: ch = 7'h52;
         7'h14: ch = 7'h54;
         7'h15: ch = 7'h59;
         7'h16: ch = 7'h55;
         7'h17: ch = 7'h49;
         7'h18: ch = 7'h4f;
         7'h19: ch = 7'h50;
         7'h1a: ch = 7'h40;
         7'h1b: ch = 7'h5b;
         7'h1e: ch = 7'h41;
         7'h1f: ch = 7'h53;
         7'h20: ch = 7'h44;
         7'h21: ch = 7'h46;
         7'h22: ch = 7'h47;
         7'h23: ch = 7'h48;
         7'h24: ch = 7'h4a;
         7'h25: ch = 7'h4b;
         7'h26: ch = 7'h4c;
         7'h27: ch = 7'h3b;
         7'h28: ch = 7'h3a;
         7'h2b: ch = 7'h5d;
         7'h2c: ch = 7'h5a;
         7'h2d: ch = 7'h58;
         7'h2e: ch = 7'h43;
         7'h2f: ch = 7'h56;
         7'h30: ch = 7'h42;
         7'h31: ch = 7'h4e;
         7'h32: ch = 7'h4d;
         7'h33: ch = 7'h2c;
         7'h34: ch = 7'h2e;
         7'h35: ch = 7'h2f;
         7'h37: ch = 7'h2a;
         7'h39: ch = 7'h20;
         7'h47: ch = 7'h37;
         7'h48: ch = 7'h38;
         7'h49: ch = 7'h39;
         7'h4a: ch = 7'h2d;
         7'h4b: ch = 7'h34;
         7'h4c: ch = 7'h35;
         7'h4d: ch = 7'h36;
         7'h4e: ch = 7'h2b;
         7'h4f: ch = 7'h31;
         7'h50: ch = 7'h32;
         7'h51: ch = 7'h33;
         7'h52: ch = 7'h30;
         7'h53: ch = 7'h2e;
         7'h73: ch = 7'h5c;
         7'h7d: ch = 7'h5c;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // Shifted map: only the entries that differ from the unshifted one
   function automatic logic [6:0] shifted_char(input logic [6:0] code);
      logic [6:0] ch;
      case (code)
         7'h02: ch = 7'h21;
         7'h03: ch = 7'h22;
         7'h04: ch = 7'h23;
         7'h05: ch = 7'h24;
         7'h06: ch = 7'h25;
         7'h07: ch = 7'h26;
         7'h08: ch = 7'h27;
         7'h09: ch = 7'h28;
         7'h0a: ch = 7'h29;
         7'h0b: ch = 7'h7e;
         7'h0c: ch = 7'h3d;
         7'h0d: ch = 7'h7e;
         7'h1a: ch = 7'h60;
         7'h1b: ch = 7'h7b;
         7'h27: ch = 7'h2b;
         7'h28: ch = 7'h2a;
         7'h2b: ch = 7'h7d;
         7'h33: ch = 7'h3c;
         7'h34: ch = 7'h3e;
         7'h35: ch = 7'h3f;
         7'h73: ch = 7'h5f;
         7'h7d: ch = 7'h7c;
         default: ch = plain_char(code);
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/keyboard_scancode_to_ascii.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | req_scan_code[7:0]
// rsp     | out       | rsp_valid/rsp_stall | rsp_char_code[6:0], rsp_char_valid,
//         |           |                     | rsp_backspace_key, rsp_tab_key
// csr     | in        | csr_wr_en           | csr_wr_data (caps lock)
//
// One beat per cycle unless rsp stalls; a beat is registered at input, then at result.
// The map lookup, case fold and shift update sit between the input and result registers.
// Synchronous active-high reset clears both valid flags, the shift state and caps lock.
// While rsp is stalled one more req beat is taken into the input register, then req stalls.
module keyboard_scancode_to_ascii (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_char_code,
   output logic       rsp_char_valid,
   output logic       rsp_backspace_key,
   output logic       rsp_tab_key,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import kbdsc_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_code_ff;
   logic       out_valid_ff;
   logic [6:0] out_char_ff;
   logic       out_char_valid_ff;
   logic       out_bs_ff;
   logic       out_tab_ff;
   shift_type  shift_ff;
   shift_type  shift_in;
   logic       caps_ff;

   logic       req_take;
   logic       advance;
   logic [6:0] map_char;
   logic [6:0] char_in;
   logic       shift_any;

   // Move the input beat on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Look up the character; letters fold to lower case unless exactly one of caps lock and shift is on
   always_comb begin
      shift_any = (shift_ff != 2'b00);
      map_char  = shift_any ? shifted_char(in_code_ff[6:0]) : plain_char(in_code_ff[6:0]);
      char_in   = 7'h00;
      if (!in_code_ff[7]) begin
         char_in = map_char;
         if ((map_char >= ASCII_UPPER_A) && (map_char <= ASCII_UPPER_Z)
             && (caps_ff == shift_any)) begin
            char_in = map_char + CASE_OFFSET;
         end
      end
   end

   // Track left and right shift press and release
   always_comb begin
      shift_in = shift_ff;
      case (in_code_ff)
         SC_LSHIFT_MAKE: shift_in[0] = 1'b1;
         SC_RSHIFT_MAKE: shift_in[1] = 1'b1;
         SC_LSHIFT_BRK:  shift_in[0] = 1'b0;
         SC_RSHIFT_BRK:  shift_in[1] = 1'b0;
         default:        shift_in = shift_ff;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shift_ff     <= 2'b00;
         caps_ff      <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            shift_ff     <= shift_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            caps_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_code_ff <= req_scan_code;
      end
      if (advance) begin
         out_char_ff       <= char_in;
         out_char_valid_ff <= (char_in != 7'h00);
         out_bs_ff         <= (in_code_ff == SC_BACKSPACE);
         out_tab_ff        <= (in_code_ff == SC_TAB);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_char_code     = out_char_ff;
   assign rsp_char_valid    = out_char_valid_ff;
   assign rsp_backspace_key = out_bs_ff;
   assign rsp_tab_key       = out_tab_ff;

   // Left shift make must leave the left shift bit set
   a_lshift_set: assert property (@(posedge clock) disable iff (reset)
      advance && (in_code_ff == SC_LSHIFT_MAKE) |=> shift_ff[0])
      else $error("left shift make did not set shift state");

   // Valid flag follows a nonzero character
   a_char_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_char_valid_ff == (out_char_ff != 7'h00)))
      else $error("char_valid does not match char_code");

   // Backspace and tab carry no character
   a_ctrl_no_char: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_bs_ff || out_tab_ff) |-> !out_char_valid_ff)
      else $error("control key produced a character");

   // Input stalls only with a full input register behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule
